// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
package spq_pkg;

	// Number of cells in the chain
	localparam int CAPACITY = 16;
	// Width of the entry count, able to hold CAPACITY itself
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int PRIO_W   = 32;
	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = ((VAL_W + PRIO_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((VAL_W + PRIO_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - (VAL_W + PRIO_W + CNT_W);

	// Operation carried in the input tuser
	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	// One stored entry
	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic signed [VAL_W-1:0]  value;
	} entry_t;

	// Shift control broadcast to every cell
	typedef struct packed {
		logic ins;  // enqueue into a non-full chain
		logic deq;  // dequeue from a non-empty chain
	} cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One cell of the priority queue chain: holds an entry and shifts with its neighbours.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    new_entry,    // entry being enqueued
	input  spq_pkg::entry_t    left_entry,   // entry of the cell nearer the head
	input  spq_pkg::entry_t    right_entry,  // entry of the cell nearer the tail
	input  logic               left_after,   // left neighbour lies at or behind the slot
	input  logic               occupied,     // this cell holds a live entry
	output spq_pkg::entry_t    entry,
	output logic               after         // this cell lies at or behind the slot
);

	spq_pkg::entry_t entry_q;

	// Cell is at or behind the insert slot when empty or strictly lower priority
	assign after = !occupied || (entry_q.prio < new_entry.prio);
	assign entry = entry_q;

	// Insert: first cell behind the slot takes the new entry, later ones shift back.
	// Dequeue: every cell takes its right neighbour. Otherwise the cell holds.
	always_ff @(posedge clk) begin
		if (ctl.ins && after) begin
			entry_q <= left_after ? left_entry : new_entry;
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
//  channel | dir | fields
//  s_*     | in  | tuser: kind; tdata: item_value, item_priority
//  m_*     | out | tuser: out_valid, rejected; tdata: out_value, out_priority, entry_count
//
// One item per cycle if not stalled: all cells compare and shift in the cycle it is taken.
// The result appears in the result register on the next cycle.
// s_tready is low only while a result waits in the register with m_tready low.
// Reset empties the queue; cell contents are not cleared and are never read while empty.
module sorted_priority_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spq_pkg::IN_DATA_W-1:0]      s_tdata,  // item_value, item_priority
	input  logic                               s_tuser,  // kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spq_pkg::OUT_DATA_W-1:0]     m_tdata,  // out_value, out_priority, entry_count, pad
	output logic [1:0]                         m_tuser   // out_valid, rejected
);

	logic                       accept;
	spq_pkg::kind_t             kind;
	spq_pkg::entry_t            new_entry;
	spq_pkg::cell_ctl_t         ctl;
	logic                       full;
	logic                       empty;
	logic [spq_pkg::CNT_W-1:0]  count_q;
	logic [spq_pkg::CNT_W-1:0]  count_next;
	logic                       m_tvalid_q;

	spq_pkg::entry_t            cell_entry [spq_pkg::CAPACITY];
	logic                       cell_after [spq_pkg::CAPACITY];

	// Result register payload
	logic                       res_valid_q;
	logic                       res_rej_q;
	spq_pkg::entry_t            res_entry_q;
	logic [spq_pkg::CNT_W-1:0]  res_count_q;

	// Input unpacking and handshake
	assign kind            = spq_pkg::kind_t'(s_tuser);
	assign new_entry.value = s_tdata[spq_pkg::VAL_W-1:0];
	assign new_entry.prio  = s_tdata[spq_pkg::VAL_W +: spq_pkg::PRIO_W];
	assign s_tready        = !m_tvalid_q || m_tready;
	assign accept          = s_tvalid && s_tready;

	assign full  = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
	assign empty = (count_q == '0);

	// Chain control
	always_comb begin
		ctl.ins = accept && (kind == spq_pkg::KIND_ENQ) && !full;
		ctl.deq = accept && (kind == spq_pkg::KIND_DEQ) && !empty;
	end

	// Next entry count
	always_comb begin
		priority if (ctl.ins) begin
			count_next = count_q + 1'b1;
		end else if (ctl.deq) begin
			count_next = count_q - 1'b1;
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Cell chain, cell 0 is the head
	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;
		logic            left_after;
		logic            occupied;

		assign occupied = (count_q > spq_pkg::CNT_W'(i));

		if (i == 0) begin : g_head
			assign left_entry = new_entry;
			assign left_after = 1'b0;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_after = cell_after[i-1];
		end

		if (i == spq_pkg::CAPACITY - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_mid
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.left_after  (left_after),
			.occupied    (occupied),
			.entry       (cell_entry[i]),
			.after       (cell_after[i])
		);
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_valid_q <= ctl.deq;
			res_rej_q   <= (kind == spq_pkg::KIND_ENQ) && full;
			res_entry_q <= ctl.deq ? cell_entry[0] : '0;
			res_count_q <= count_next;
		end
	end

	// Output packing
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {res_rej_q, res_valid_q};
	assign m_tdata  = {{spq_pkg::OUT_PAD_W{1'b0}}, res_count_q,
	                   res_entry_q.prio, res_entry_q.value};

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: random stream traffic against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	// Expected outcome of one item, fields as carried on the output stream
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0]  value;
		logic [PRIO_W-1:0] prio;
		logic             rejected;
		logic [CNT_W-1:0]  count;
	} pq_result_t;

	// One input item waiting to be sent
	typedef struct {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  value;
		logic signed [PRIO_W-1:0] prio;
	} pq_item_t;

	localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // item_value, item_priority
	logic                  s_tuser  = KIND_ENQ;  // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // out_value, out_priority, entry_count, pad
	logic [1:0]            m_tuser;  // out_valid, rejected

	// Traffic control shared by stimulus, driver and receiver
	pq_item_t   item_feed[$];
	pq_result_t results_due[$];
	int unsigned items_pushed   = 0;
	int unsigned items_accepted = 0;
	int unsigned err_cnt        = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_idle_pct  = 0;
	bit          s_fire         = 1'b0;
	bit          hold_go        = 1'b0;
	bit          hold_on        = 1'b0;

	// Predictor state: the ordered store and its fill level
	entry_t      queue_cells[CAPACITY];
	int unsigned queue_fill = 0;

	sorted_priority_queue_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Apply one item to the predicted store and return its outcome
	function automatic pq_result_t queue_apply(kind_t kind, logic signed [VAL_W-1:0] value,
			logic signed [PRIO_W-1:0] prio);
		pq_result_t r;
		int unsigned pos;
		r = '0;
		if (kind == KIND_ENQ) begin
			if (queue_fill >= CAPACITY) begin
				r.rejected = 1'b1;
			end else begin
				// new entry goes behind every entry of equal or higher priority
				pos = queue_fill;
				for (int unsigned i = 0; i < queue_fill; i++) begin
					if (queue_cells[i].prio < prio) begin
						pos = i;
						break;
					end
				end
				for (int unsigned i = queue_fill; i > pos; i--)
					queue_cells[i] = queue_cells[i-1];
				queue_cells[pos].value = value;
				queue_cells[pos].prio  = prio;
				queue_fill++;
			end
		end else if (queue_fill != 0) begin
			r.hit   = 1'b1;
			r.value = queue_cells[0].value;
			r.prio  = queue_cells[0].prio;
			for (int unsigned i = 1; i < queue_fill; i++)
				queue_cells[i-1] = queue_cells[i];
			queue_fill--;
		end
		r.count = CNT_W'(queue_fill);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
			err_cnt++;
		end
	endtask

	// Monitor: check results, then record accepted items and predict their outcome
	always @(posedge clk) begin
		pq_result_t want;
		if (!arst_n) begin
			s_fire = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, got tdata %h tuser %b",
						$realtime, m_tdata, m_tuser);
					err_cnt++;
				end else begin
					want = results_due.pop_front();
					check_field("out_valid", want.hit, m_tuser[0]);
					check_field("rejected", want.rejected, m_tuser[1]);
					check_field("out_value", want.value, m_tdata[31:0]);
					check_field("out_priority", want.prio, m_tdata[63:32]);
					check_field("entry_count", want.count, m_tdata[64 +: CNT_W]);
				end
			end
			s_fire = s_tvalid && s_tready;
			if (s_fire) begin
				results_due.push_back(queue_apply(kind_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
				items_accepted++;
			end
		end
	end

	// Driver: present the next item once the current one is taken
	always @(negedge clk) begin
		pq_item_t it;
		if (!s_tvalid || s_fire) begin
			if (item_feed.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				it = item_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {it.prio, it.value};
				s_tuser  <= it.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, forced low during a hold-off
	always @(negedge clk)
		m_tready <= !hold_on && ($urandom_range(99, 0) >= recv_idle_pct);

	// Long receiver hold-off, counted here
	initial begin
		wait (hold_go);
		hold_on = 1'b1;
		repeat (120) @(posedge clk);
		hold_on = 1'b0;
	end

	task automatic push_item(kind_t kind, logic signed [31:0] value, logic signed [31:0] prio);
		pq_item_t it;
		it.kind  = kind;
		it.value = value;
		it.prio  = prio;
		item_feed.push_back(it);
		items_pushed++;
	endtask

	// Random walk: chunks biased towards filling, draining or neither
	task automatic push_random(int unsigned n);
		int unsigned enq_pct;
		logic signed [31:0] prio;
		enq_pct = 50;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 20 == 0) begin
				case ($urandom_range(2, 0))
					0: enq_pct = 85;
					1: enq_pct = 20;
					default: enq_pct = 50;
				endcase
			end
			case ($urandom_range(3, 0))
				0: prio = $urandom_range(4, 0) - 2;  // narrow range for ties
				1: begin
					case ($urandom_range(3, 0))
						0: prio = PRIO_MAX;
						1: prio = PRIO_MIN;
						2: prio = 0;
						default: prio = -1;
					endcase
				end
				default: prio = $urandom;
			endcase
			push_item(($urandom_range(99, 0) < enq_pct) ? KIND_ENQ : KIND_DEQ, $urandom, prio);
		end
	endtask

	// Wait until every item has been taken and every result has come
	task automatic drain();
		while (items_accepted != items_pushed || results_due.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Stimulus and end of run
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty dequeue, extremes, ties, full store, dequeues
		send_idle_pct = 17;
		recv_idle_pct = 75;
		push_item(KIND_DEQ, 32'sh1234_5678, PRIO_MAX);
		push_item(KIND_ENQ, PRIO_MAX, 0);
		push_item(KIND_ENQ, PRIO_MIN, 0);
		push_item(KIND_ENQ, 0, PRIO_MAX);
		push_item(KIND_ENQ, -1, PRIO_MIN);
		push_item(KIND_ENQ, 5, -1);
		push_item(KIND_ENQ, 6, 1);
		push_item(KIND_ENQ, 7, 0);
		push_item(KIND_ENQ, 8, PRIO_MAX);
		push_item(KIND_ENQ, 9, PRIO_MIN);
		for (int i = 10; i < 17; i++)
			push_item(KIND_ENQ, i, i - 13);
		push_item(KIND_ENQ, 32'sh5555_aaaa, PRIO_MAX);  // store full
		repeat (5) push_item(KIND_DEQ, 0, 0);

		push_random(250);
		drain();

		// Swapped idling, with a long receiver hold-off while items are offered
		send_idle_pct = 75;
		recv_idle_pct = 17;
		push_random(200);
		hold_go = 1'b1;
		drain();

		// No idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random(200);
		drain();

		repeat (20) @(posedge clk);
		if (err_cnt == 0 && results_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Timeout
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
